/* rtl/btd_pkg.sv */
// ----------------------------------------------------------------------------
// BER TLV decoder package
// Shared result codes, the result beat type and the small helper functions
// used by the decoder and its result queue.
// ----------------------------------------------------------------------------
package btd_pkg;

   // Result kinds.
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_INTEGER = 3'd1;
   localparam logic [2:0] KIND_OID_ARC = 3'd2;
   localparam logic [2:0] KIND_BYTE    = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_INDEFINITE = 2'd1;
   localparam logic [1:0] ERR_LEN_LONG   = 2'd2;
   localparam logic [1:0] ERR_INT_LONG   = 2'd3;

   // Configuration register indexes.
   localparam int         CSR_INDEX_W     = 1;
   localparam logic       CSR_INTEGER_TAG = 1'b0;
   localparam logic       CSR_OID_TAG     = 1'b1;
   localparam logic [7:0] INTEGER_TAG_RST = 8'd2;
   localparam logic [7:0] OID_TAG_RST     = 8'd6;

   // Encoding constants.
   localparam logic [7:0]  LEN_INDEFINITE = 8'h80;
   localparam logic [31:0] INT_MAX_BYTES  = 32'd4;
   localparam logic [7:0]  OID_DIVISOR    = 8'd40;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  elem_tag;
      logic [31:0] elem_length;
      logic [31:0] value;
      logic [1:0]  error_code;
      logic        element_done;
      logic        last;
   } btd_result_type;

   // Results caused by one input byte: zero, one or two of them.
   typedef struct packed {
      logic [1:0]     count;
      btd_result_type first;
      btd_result_type second;
   } btd_push_type;

   function automatic btd_result_type make_result(input logic [2:0]  kind,
                                                  input logic [7:0]  tag,
                                                  input logic [31:0] len,
                                                  input logic [31:0] value,
                                                  input logic [1:0]  err,
                                                  input logic        done);
      btd_result_type r;
      r.kind         = kind;
      r.elem_tag     = tag;
      r.elem_length  = len;
      r.value        = value;
      r.error_code   = err;
      r.element_done = done;
      r.last         = 1'b0;
      return r;
   endfunction

   // x / 40 for a byte: (x / 8) / 5, with the divide by 5 done as a multiply
   // by 13/64, which is exact for quotients of values below 32.
   function automatic logic [2:0] div40(input logic [7:0] x);
      logic [8:0] prod;
      prod = 9'(x[7:3]) * 9'd13;
      return prod[8:6];
   endfunction

   function automatic logic [7:0] mod40(input logic [7:0] x);
      logic [7:0] q;
      q = {5'd0, div40(x)};
      return 8'(x - q * OID_DIVISOR);
   endfunction

endpackage

/* rtl/btd_req_if.sv */
// ----------------------------------------------------------------------------
// BER TLV decoder input channel
// Valid/ready channel that carries one byte of the encoded stream per beat.
// ----------------------------------------------------------------------------
interface btd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/btd_rsp_if.sv */
// ----------------------------------------------------------------------------
// BER TLV decoder result channel
// Valid/ready channel that carries one decoded result per beat.
// ----------------------------------------------------------------------------
interface btd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  elem_tag;
   logic [31:0] elem_length;
   logic [31:0] value;
   logic [1:0]  error_code;
   logic        element_done;
   logic        last;

   modport source (output valid, output kind, output elem_tag, output elem_length,
                   output value, output error_code, output element_done,
                   output last, input ready);
   modport sink   (input valid, input kind, input elem_tag, input elem_length,
                   input value, input error_code, input element_done,
                   input last, output ready);
endinterface

/* rtl/btd_result_queue.sv */
// ----------------------------------------------------------------------------
// BER TLV decoder result queue
// Shifting queue of result beats; takes up to two results per cycle while it
// has room for two, and presents the oldest one on the result channel.
// ----------------------------------------------------------------------------
module btd_result_queue import btd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  btd_push_type  push,
   output logic          room,
   btd_rsp_if.source     rsp_ch
);

   btd_result_type        q_ff    [QUEUE_DEPTH];
   btd_result_type        q_in    [QUEUE_DEPTH];
   btd_result_type        shifted [QUEUE_DEPTH];
   logic [QCOUNT_W-1:0]   count_ff;
   logic [QCOUNT_W-1:0]   count_in;
   logic [QCOUNT_W-1:0]   base;
   logic                  pop;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign base = count_ff - QCOUNT_W'(pop);
   assign room = count_ff <= QCOUNT_W'(QUEUE_DEPTH - 2);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      shifted[QUEUE_DEPTH - 1] = q_ff[QUEUE_DEPTH - 1];
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.count != 2'd0 && base == QCOUNT_W'(i)) begin
            q_in[i] = push.first;
         end else if (push.count == 2'd2 && base + QCOUNT_W'(1) == QCOUNT_W'(i)) begin
            q_in[i] = push.second;
         end else begin
            q_in[i] = shifted[i];
         end
      end
      count_in = base + QCOUNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.kind         = q_ff[0].kind;
   assign rsp_ch.elem_tag     = q_ff[0].elem_tag;
   assign rsp_ch.elem_length  = q_ff[0].elem_length;
   assign rsp_ch.value        = q_ff[0].value;
   assign rsp_ch.error_code   = q_ff[0].error_code;
   assign rsp_ch.element_done = q_ff[0].element_done;
   assign rsp_ch.last         = q_ff[0].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("results pushed without room for two");

   a_pair_visible: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |=> count_ff >= QCOUNT_W'(2))
      else $error("a result pair was lost in the queue");

endmodule

/* rtl/ber_tlv_stream_decoder.sv */
// ----------------------------------------------------------------------------
// BER TLV stream decoder
// Decodes an ASN.1 BER/DER byte stream into header, integer, OID arc,
// content byte and error results.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before the result channel sees them.
// Takes one byte per cycle while the queue has room, decoding it in one pass.
// A byte that causes two results needs two result beats; the input stalls
// only while the four-entry result queue holds more than two results.
// Reset (synchronous, active high) returns the parser to the tag phase,
// empties the result queue and loads integer_tag = 2 and oid_tag = 6.
module ber_tlv_stream_decoder import btd_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   btd_req_if.sink                req_ch,
   btd_rsp_if.source              rsp_ch
);

   // Width of the long-form length byte counter.
   localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

   // Parser phases.
   localparam logic [2:0] PH_TAG     = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_LENLONG = 3'd2;
   localparam logic [2:0] PH_INT     = 3'd3;
   localparam logic [2:0] PH_OID     = 3'd4;
   localparam logic [2:0] PH_RAW     = 3'd5;
   localparam logic [2:0] PH_INTSKIP = 3'd6;

   logic [7:0]    integer_tag_ff;
   logic [7:0]    oid_tag_ff;
   logic [2:0]    phase_ff,        phase_in;
   logic [7:0]    tag_ff,          tag_in;
   logic [LW-1:0] len_left_ff,     len_left_in;
   logic [31:0]   len_acc_ff,      len_acc_in;
   logic [31:0]   content_left_ff, content_left_in;
   logic [31:0]   val_acc_ff,      val_acc_in;
   logic          first_oid_ff,    first_oid_in;

   logic          accept;
   logic          room;
   logic [7:0]    in_byte;
   logic [6:0]    len_cnt;
   logic [31:0]   content_dec;
   logic          content_done;
   logic [31:0]   int_val;
   logic [31:0]   oid_val;
   logic          do_header;
   logic [31:0]   hdr_len;
   logic          is_int;
   logic          is_oid;
   btd_push_type  push;

   // The input is taken whenever the result queue can absorb a result pair.
   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;
   assign in_byte      = req_ch.in_byte;

   assign len_cnt      = in_byte[6:0];
   assign content_dec  = content_left_ff - 32'd1;
   assign content_done = content_dec == 32'd0;
   // Integers gather big-endian whole bytes; OID arcs gather seven bits a byte.
   assign int_val      = {val_acc_ff[23:0], in_byte};
   assign oid_val      = {val_acc_ff[24:0], in_byte[6:0]};
   assign is_int       = tag_ff == integer_tag_ff;
   assign is_oid       = tag_ff == oid_tag_ff;

   always_comb begin
      phase_in        = phase_ff;
      tag_in          = tag_ff;
      len_left_in     = len_left_ff;
      len_acc_in      = len_acc_ff;
      content_left_in = content_left_ff;
      val_acc_in      = val_acc_ff;
      first_oid_in    = first_oid_ff;
      do_header       = 1'b0;
      hdr_len         = len_acc_ff;
      push.count      = 2'd0;
      push.first      = make_result(KIND_HEADER, tag_ff, len_acc_ff, 32'd0, ERR_NONE, 1'b0);
      push.second     = push.first;

      if (accept) begin
         unique case (phase_ff)
            PH_TAG: begin
               tag_in   = in_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_acc_in = 32'd0;
               if (in_byte == LEN_INDEFINITE) begin
                  // Indefinite length is not supported: report and resync on a tag.
                  phase_in   = PH_TAG;
                  push.count = 2'd1;
                  push.first = make_result(KIND_ERROR, tag_ff, 32'd0, 32'd0,
                                           ERR_INDEFINITE, 1'b1);
               end else if (in_byte[7]) begin
                  if (len_cnt == 7'd0) begin
                     do_header = 1'b1;
                     hdr_len   = 32'd0;
                  end else if (len_cnt > 7'(MAX_LENGTH_BYTES)) begin
                     // The length bytes are not skipped; the next byte is a tag.
                     phase_in   = PH_TAG;
                     push.count = 2'd1;
                     push.first = make_result(KIND_ERROR, tag_ff, 32'd0, 32'd0,
                                              ERR_LEN_LONG, 1'b1);
                  end else begin
                     len_left_in = LW'(len_cnt);
                     phase_in    = PH_LENLONG;
                  end
               end else begin
                  do_header = 1'b1;
                  hdr_len   = {24'd0, in_byte};
               end
            end
            PH_LENLONG: begin
               // Bits shifted out of the top of the accumulator are lost.
               hdr_len    = {len_acc_ff[23:0], in_byte};
               len_acc_in = hdr_len;
               if (len_left_ff != '0) begin
                  len_left_in = len_left_ff - LW'(1);
               end
               do_header = len_left_ff <= LW'(1);
            end
            default: begin
               content_left_in = content_dec;
               if (phase_ff == PH_INT) begin
                  val_acc_in = int_val;
                  if (content_done) begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_INTEGER, tag_ff, len_acc_ff, int_val,
                                              ERR_NONE, 1'b1);
                  end
               end else if (phase_ff == PH_INTSKIP) begin
                  if (content_done) begin
                     push.count  = 2'd2;
                     push.first  = make_result(KIND_INTEGER, tag_ff, len_acc_ff, 32'd0,
                                               ERR_NONE, 1'b0);
                     push.second = make_result(KIND_ERROR, tag_ff, len_acc_ff, 32'd0,
                                               ERR_INT_LONG, 1'b1);
                  end
               end else if (phase_ff == PH_OID) begin
                  if (first_oid_ff) begin
                     // The first byte packs two arcs as 40 * x + y.
                     first_oid_in = 1'b0;
                     push.count   = 2'd2;
                     push.first   = make_result(KIND_OID_ARC, tag_ff, len_acc_ff,
                                                {29'd0, div40(in_byte)}, ERR_NONE, 1'b0);
                     push.second  = make_result(KIND_OID_ARC, tag_ff, len_acc_ff,
                                                {24'd0, mod40(in_byte)}, ERR_NONE,
                                                content_done);
                  end else begin
                     val_acc_in = oid_val;
                     // An arc cut off by the end of content is reported as it stands.
                     if (!in_byte[7] || content_done) begin
                        push.count = 2'd1;
                        push.first = make_result(KIND_OID_ARC, tag_ff, len_acc_ff, oid_val,
                                                 ERR_NONE, content_done);
                        val_acc_in = 32'd0;
                     end
                  end
               end else begin
                  push.count = 2'd1;
                  push.first = make_result(KIND_BYTE, tag_ff, len_acc_ff, {24'd0, in_byte},
                                           ERR_NONE, content_done);
               end
               if (content_done) begin
                  phase_in = PH_TAG;
               end
            end
         endcase

         if (do_header) begin
            // The length is complete: report the header and pick the content
            // decoder. The integer tag wins over the OID tag, and both win over
            // the constructed bit; other constructed elements go to a nested tag.
            len_acc_in      = hdr_len;
            val_acc_in      = 32'd0;
            first_oid_in    = 1'b1;
            content_left_in = hdr_len;
            phase_in        = PH_TAG;
            push.count      = 2'd1;
            push.first      = make_result(KIND_HEADER, tag_ff, hdr_len, 32'd0,
                                          ERR_NONE, 1'b0);
            if (is_int) begin
               if (hdr_len == 32'd0) begin
                  // An empty integer still yields a value of zero.
                  push.count  = 2'd2;
                  push.second = make_result(KIND_INTEGER, tag_ff, hdr_len, 32'd0,
                                            ERR_NONE, 1'b1);
               end else begin
                  phase_in = (hdr_len > INT_MAX_BYTES) ? PH_INTSKIP : PH_INT;
               end
            end else if (!is_oid && tag_ff[5]) begin
               phase_in = PH_TAG;
            end else if (hdr_len == 32'd0) begin
               push.first.element_done = 1'b1;
            end else begin
               phase_in = is_oid ? PH_OID : PH_RAW;
            end
         end
      end

      // Mark the final result caused by this byte.
      if (push.count == 2'd1) begin
         push.first.last = 1'b1;
      end
      if (push.count == 2'd2) begin
         push.second.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integer_tag_ff  <= INTEGER_TAG_RST;
         oid_tag_ff      <= OID_TAG_RST;
         phase_ff        <= PH_TAG;
         tag_ff          <= 8'd0;
         len_left_ff     <= '0;
         len_acc_ff      <= 32'd0;
         content_left_ff <= 32'd0;
         val_acc_ff      <= 32'd0;
         first_oid_ff    <= 1'b1;
      end else begin
         if (csr_we && csr_index == CSR_INTEGER_TAG) begin
            integer_tag_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_OID_TAG) begin
            oid_tag_ff <= csr_wdata;
         end
         phase_ff        <= phase_in;
         tag_ff          <= tag_in;
         len_left_ff     <= len_left_in;
         len_acc_ff      <= len_acc_in;
         content_left_ff <= content_left_in;
         val_acc_ff      <= val_acc_in;
         first_oid_ff    <= first_oid_in;
      end
   end

   btd_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   // A content phase always has at least one content byte still to come.
   a_content_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_INT || phase_ff == PH_INTSKIP || phase_ff == PH_OID ||
       phase_ff == PH_RAW) |-> content_left_ff != 32'd0)
      else $error("content phase entered with no content left");

   a_lenlong_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LENLONG |->
         (len_left_ff != '0 && len_left_ff <= LW'(MAX_LENGTH_BYTES)))
      else $error("long-form length byte count out of range");

   a_tag_then_len: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_TAG) |=> phase_ff == PH_LEN)
      else $error("a tag byte was not followed by the length phase");

endmodule
